### design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page allocator: field widths,
// command and status codes, the page map entry and the result bundle.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // Default geometry of the managed memory.
  localparam int PAGES_DFLT      = 256;
  localparam int PAGE_BYTES_DFLT = 4096;

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int REQ_W  = 21;
  localparam int OFF_W  = 20;
  localparam int STAT_W = 2;
  localparam int RUN_W  = 9;
  localparam int CFG_W  = 9;

  // Reset value of the managed page count register.
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FREE  = 2'd3;

  // One page map entry: allocated bit and run length at a run's first page.
  typedef struct packed {
    logic             taken;
    logic [RUN_W-1:0] run;
  } page_entry_t;

  // Result of one request.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  start_offset;
    logic [REQ_W-1:0]  run_bytes;
  } result_t;

endpackage

### design/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ffpa_seq.sv
// ----------------------------------------------------------------------------
// ffpa_seq
// Request sequencer of the page allocator. It sweeps the page map memory one
// entry per cycle: a clearing pass after reset, a read scan for each request,
// and a write pass that marks or frees a run.
// ----------------------------------------------------------------------------
module ffpa_seq
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES  = PAGES_DFLT,
  parameter int PAGE_BYTES = PAGE_BYTES_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [CMD_W-1:0]              cmd,
  input  logic [REQ_W-1:0]              req_bytes,
  input  logic [OFF_W-1:0]              byte_off,
  input  logic [$clog2(NUM_PAGES+1)-1:0] lim,
  output logic                          busy,
  output logic                          done,
  output result_t                       res,
  output logic                          mem_we,
  output logic [$clog2(NUM_PAGES)-1:0]  mem_waddr,
  output page_entry_t                   mem_wdata,
  output logic [$clog2(NUM_PAGES)-1:0]  mem_raddr,
  input  page_entry_t                   mem_rdata
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int LW = $clog2(NUM_PAGES+1);
  // Byte arithmetic wide enough for a run that starts near the last page.
  localparam int BW = $clog2((NUM_PAGES + 512) * PAGE_BYTES) + 1;
  localparam int CW = (BW > REQ_W + 1) ? BW : REQ_W + 1;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [CW-1:0]     req_r, req_nxt;
  logic [CW-1:0]     off_r, off_nxt;
  logic [LW-1:0]     a_r, a_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     run_lo_r, run_lo_nxt;
  logic [AW-1:0]     run_start_r, run_start_nxt;
  logic [RUN_W-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]     fb_r, fb_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [AW-1:0]     mend_r, mend_nxt;

  page_entry_t       ent;
  logic [CW-1:0]     lo_next;
  logic [CW-1:0]     fb_add;
  logic [CW-1:0]     run_len;
  logic [CW-1:0]     hi;
  logic              stop;
  logic [STAT_W-1:0] miss_status;

  assign busy = (state_r != S_IDLE);

  // Byte arithmetic on the entry being checked.
  always_comb begin
    ent     = mem_rdata;
    lo_next = lo_r + CW'(PAGE_BYTES);
    fb_add  = fb_r + CW'(PAGE_BYTES);
    run_len = CW'(ent.run) * CW'(PAGE_BYTES);
    hi      = lo_r + run_len;
  end

  // Status of a scan that ran off the managed pages.
  always_comb begin
    case (cmd_r)
      CMD_ALLOC: miss_status = ST_NO_SPACE;
      CMD_FREE:  miss_status = ST_BAD_FREE;
      default:   miss_status = ST_NOT_FOUND;
    endcase
  end

  // Sequencer next state and memory accesses.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    a_nxt         = a_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    lo_nxt        = lo_r;
    run_lo_nxt    = run_lo_r;
    run_start_nxt = run_start_r;
    cnt_nxt       = cnt_r;
    fb_nxt        = fb_r;
    wpos_nxt      = wpos_r;
    mend_nxt      = mend_r;
    done          = 1'b0;
    res           = '0;
    mem_we        = 1'b0;
    mem_waddr     = wpos_r;
    mem_wdata     = '0;
    mem_raddr     = AW'(a_r);
    stop          = 1'b0;

    case (state_r)
      // Clearing pass over the whole map after reset.
      S_INIT: begin
        mem_we = 1'b1;
        if (wpos_r == AW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          wpos_nxt = wpos_r + AW'(1);
        end
      end

      // Take a request; trivial ones answer at once.
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = cmd;
          req_nxt       = CW'(req_bytes);
          off_nxt       = CW'(byte_off);
          a_nxt         = '0;
          chk_vld_nxt   = 1'b0;
          lo_nxt        = '0;
          run_lo_nxt    = '0;
          run_start_nxt = '0;
          cnt_nxt       = '0;
          fb_nxt        = '0;
          if (cmd == CMD_ALLOC && req_bytes == '0) begin
            done       = 1'b1;
            res.status = ST_NO_SPACE;
          end else if (cmd != CMD_ALLOC && cmd != CMD_FREE && cmd != CMD_FIND) begin
            done       = 1'b1;
            res.status = ST_NOT_FOUND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Read one entry per cycle and check the one read last cycle.
      S_SCAN: begin
        if (chk_vld_r) begin
          lo_nxt = lo_next;
          case (cmd_r)
            CMD_ALLOC: begin
              if (ent.taken) begin
                fb_nxt        = '0;
                cnt_nxt       = '0;
                run_start_nxt = chk_idx_r + AW'(1);
                run_lo_nxt    = lo_next;
              end else begin
                fb_nxt  = fb_add;
                cnt_nxt = cnt_r + RUN_W'(1);
                if (fb_add >= req_r) begin
                  stop        = 1'b1;
                  state_nxt   = S_MARK;
                  wpos_nxt    = run_start_r;
                  mend_nxt    = chk_idx_r;
                  chk_vld_nxt = 1'b0;
                end
              end
            end
            CMD_FREE: begin
              // This page holds the offset.
              if (off_r < lo_next) begin
                stop        = 1'b1;
                chk_vld_nxt = 1'b0;
                if (ent.taken && ent.run != '0) begin
                  state_nxt  = S_CLEAR;
                  wpos_nxt   = chk_idx_r;
                  cnt_nxt    = ent.run;
                  run_lo_nxt = lo_r;
                end else begin
                  state_nxt  = S_IDLE;
                  done       = 1'b1;
                  res.status = ST_BAD_FREE;
                end
              end
            end
            default: begin
              if (ent.taken && ent.run != '0 && off_r >= lo_r && off_r < hi) begin
                stop             = 1'b1;
                chk_vld_nxt      = 1'b0;
                state_nxt        = S_IDLE;
                done             = 1'b1;
                res.status       = ST_OK;
                res.start_offset = lo_r[OFF_W-1:0];
                res.run_bytes    = run_len[REQ_W-1:0];
              end
            end
          endcase
        end
        if (!stop) begin
          if (a_r < lim) begin
            a_nxt       = a_r + LW'(1);
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = AW'(a_r);
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              state_nxt  = S_IDLE;
              done       = 1'b1;
              res.status = miss_status;
            end
          end
        end
      end

      // Mark the found run; its first page carries the length.
      S_MARK: begin
        mem_we          = 1'b1;
        mem_wdata.taken = 1'b1;
        mem_wdata.run   = (wpos_r == run_start_r) ? cnt_r : '0;
        if (wpos_r == mend_r) begin
          state_nxt        = S_IDLE;
          done             = 1'b1;
          res.status       = ST_OK;
          res.start_offset = run_lo_r[OFF_W-1:0];
        end else begin
          wpos_nxt = wpos_r + AW'(1);
        end
      end

      // Clear the freed run, stopping at the end of the map.
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == RUN_W'(1) || wpos_r == AW'(NUM_PAGES - 1)) begin
          state_nxt        = S_IDLE;
          done             = 1'b1;
          res.status       = ST_OK;
          res.start_offset = run_lo_r[OFF_W-1:0];
        end else begin
          wpos_nxt = wpos_r + AW'(1);
          cnt_nxt  = cnt_r - RUN_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      wpos_r    <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wpos_r    <= wpos_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    a_r         <= a_nxt;
    chk_idx_r   <= chk_idx_nxt;
    lo_r        <= lo_nxt;
    run_lo_r    <= run_lo_nxt;
    run_start_r <= run_start_nxt;
    cnt_r       <= cnt_nxt;
    fb_r        <= fb_nxt;
    mend_r      <= mend_nxt;
  end

`ifndef ASSERT_OFF
  // The map is never written during a scan.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("page map written during a scan");

  // A checked entry always lies inside the managed pages.
  a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_vld_r) |-> ((LW+1)'(chk_idx_r) < (LW+1)'(lim)))
    else $error("scan checked an entry past the limit");

  // A finished request returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == S_IDLE))
    else $error("sequencer not idle after a result");

  // No result during the clearing pass after reset.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !done)
    else $error("result produced during the clearing pass");

  // A mark pass never runs past the page that completed the run.
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK && wpos_r == mend_r) |=> (state_r == S_IDLE))
    else $error("mark pass overran its run");
`endif

endmodule

### design/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator with a page map held in a synchronous
// RAM: allocate, free and find requests over a configurable page count.
// ----------------------------------------------------------------------------
// Scan: find and allocate read up to L = min(pages_in_use, NUM_PAGES) map
// entries, free up to entry P, the page index of the offset; allocate then
// marks and free then clears the run, one page at a time.
// Requests are handled one at a time; a new one is taken only while busy is low.
// The result strobe follows the finishing cycle; the receiver cannot stall.
// Reset: the map is cleared page by page, busy stays high meanwhile.
// ----------------------------------------------------------------------------
module first_fit_page_allocator
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES  = PAGES_DFLT,
  parameter int PAGE_BYTES = PAGE_BYTES_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  // Request channel
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [OFF_W-1:0]  in_byte_offset,
  // Result channel
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [OFF_W-1:0]  out_start_offset,
  output logic [REQ_W-1:0]  out_run_bytes,
  // Configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_pages_in_use
);

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int LW   = $clog2(NUM_PAGES+1);
  localparam int CMPW = (LW > CFG_W) ? LW : CFG_W;

  logic [CFG_W-1:0] pages_r;
  logic [LW-1:0]    lim;
  logic             seq_done;
  result_t          seq_res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  page_entry_t      mem_wdata;
  page_entry_t      mem_rdata;
  logic             out_valid_r;
  result_t          out_res_r;

  // Page count register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pages_r <= cfg_pages_in_use;
    end
  end

  // Scan limit: the smaller of the register and the map depth.
  assign lim = (CMPW'(pages_r) < CMPW'(NUM_PAGES)) ? LW'(pages_r) : LW'(NUM_PAGES);

  ffpa_seq #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (in_command),
    .req_bytes(in_request_bytes),
    .byte_off (in_byte_offset),
    .lim      (lim),
    .busy     (busy),
    .done     (seq_done),
    .res      (seq_res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ffpa_ram #(
    .WIDTH($bits(page_entry_t)),
    .DEPTH(NUM_PAGES)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Result register: one-cycle strobe with its payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_done;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_start_offset = out_res_r.start_offset;
  assign out_run_bytes    = out_res_r.run_bytes;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives allocate, free and find requests into the allocator under several
// managed page counts, predicts every reply from a private copy of the page
// map and compares each reply field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import ffpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES       = PAGES_DFLT;
  localparam int PBYTES      = PAGE_BYTES_DFLT;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 98;

  // The command encoding left unused by the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Page map tracker: mirrors the allocator state and holds the replies
  // that accepted requests still owe.
  class page_map_tracker;
    bit               taken [PAGES];
    logic [RUN_W-1:0] run_len [PAGES];
    logic [CFG_W-1:0] page_count;
    result_t          owed_replies [$];
    int               errors;

    function new();
      foreach (taken[i]) begin
        taken[i]   = 1'b0;
        run_len[i] = '0;
      end
      page_count = CFG_RESET;
      errors     = 0;
    endfunction

    function int scan_limit();
      return (page_count < PAGES) ? int'(page_count) : PAGES;
    endfunction

    function void set_page_count(logic [CFG_W-1:0] value);
      page_count = value;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Picks a random allocation that is currently live anywhere in the map.
    function bit pick_live(output int first_page, output int pages);
      int starts [$];
      int pick;
      first_page = 0;
      pages      = 0;
      foreach (taken[i]) begin
        if (taken[i] && run_len[i] != 0) starts.push_back(i);
      end
      if (starts.size() == 0) return 1'b0;
      pick       = starts[$urandom_range(0, starts.size() - 1)];
      first_page = pick;
      pages      = int'(run_len[pick]);
      return 1'b1;
    endfunction

    // Works out the reply to one request and updates the map.
    function result_t predict_reply(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                                    logic [OFF_W-1:0] off);
      result_t rep;
      int      lim;
      int      need;
      int      free_run;
      int      first;
      int      page;
      int      lo;
      int      len;
      bit      found;
      rep   = '0;
      lim   = scan_limit();
      found = 1'b0;
      case (cmd)
        CMD_ALLOC: begin
          rep.status = ST_NO_SPACE;
          need       = (int'(req) + PBYTES - 1) / PBYTES;
          free_run   = 0;
          if (need != 0 && need <= lim) begin
            for (int i = 0; i < lim && !found; i++) begin
              free_run = taken[i] ? 0 : free_run + 1;
              if (free_run >= need) begin
                first = i + 1 - free_run;
                for (int k = 0; k < free_run; k++) taken[first + k] = 1'b1;
                run_len[first]   = RUN_W'(free_run);
                rep.status       = ST_OK;
                rep.start_offset = OFF_W'(first * PBYTES);
                found            = 1'b1;
              end
            end
          end
        end
        CMD_FREE: begin
          rep.status = ST_BAD_FREE;
          page       = int'(off) / PBYTES;
          if (page < lim && taken[page] && run_len[page] != 0) begin
            len = int'(run_len[page]);
            for (int k = 0; k < len; k++) begin
              if (page + k < PAGES) begin
                taken[page + k]   = 1'b0;
                run_len[page + k] = '0;
              end
            end
            rep.status       = ST_OK;
            rep.start_offset = OFF_W'(page * PBYTES);
          end
        end
        CMD_FIND: begin
          rep.status = ST_NOT_FOUND;
          for (int i = 0; i < lim && !found; i++) begin
            if (taken[i] && run_len[i] != 0) begin
              lo  = i * PBYTES;
              len = int'(run_len[i]) * PBYTES;
              if (int'(off) >= lo && int'(off) < lo + len) begin
                rep.status       = ST_OK;
                rep.start_offset = OFF_W'(lo);
                rep.run_bytes    = REQ_W'(len);
                found            = 1'b1;
              end
            end
          end
        end
        default: rep.status = ST_NOT_FOUND;
      endcase
      return rep;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                               logic [OFF_W-1:0] off);
      owed_replies.push_back(predict_reply(cmd, req, off));
    endfunction

    function void check_reply(logic [STAT_W-1:0] status, logic [OFF_W-1:0] start_offset,
                              logic [REQ_W-1:0] run_bytes);
      result_t exp_rep;
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with no request waiting, status %0d start %0h bytes %0h",
                 $time, status, start_offset, run_bytes);
        errors++;
        return;
      end
      exp_rep = owed_replies.pop_front();
      if (status !== exp_rep.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_rep.status, status);
        errors++;
      end
      if (start_offset !== exp_rep.start_offset) begin
        $display("%0t: start_offset mismatch, expected %0h, actual %0h",
                 $time, exp_rep.start_offset, start_offset);
        errors++;
      end
      if (run_bytes !== exp_rep.run_bytes) begin
        $display("%0t: run_bytes mismatch, expected %0h, actual %0h",
                 $time, exp_rep.run_bytes, run_bytes);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_command       = '0;
  logic [REQ_W-1:0]  in_request_bytes = '0;
  logic [OFF_W-1:0]  in_byte_offset   = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [OFF_W-1:0]  out_start_offset;
  logic [REQ_W-1:0]  out_run_bytes;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_pages_in_use = '0;

  page_map_tracker tracker;
  bit              no_idle = 1'b0;
  int              cycles  = 0;

  first_fit_page_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_request_bytes (in_request_bytes),
    .in_byte_offset   (in_byte_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_start_offset (out_start_offset),
    .out_run_bytes    (out_run_bytes),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pages_in_use (cfg_pages_in_use)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every strobed reply is checked against the oldest owed reply.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_reply(out_status, out_start_offset, out_run_bytes);
    end
  end

  // Presents one request after a random gap, none when no_idle is set, and waits until busy is low.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] req,
                              input logic [OFF_W-1:0] off);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= cmd;
    in_request_bytes <= req;
    in_byte_offset   <= off;
    do @(posedge clk); while (busy);
    tracker.note_request(cmd, req, off);
  endtask

  // Holds requests off until every owed reply has arrived.
  task automatic wait_replies_done();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Writes the managed page count once the block has gone idle.
  task automatic write_page_count(input logic [CFG_W-1:0] value);
    wait_replies_done();
    cfg_valid        <= 1'b1;
    cfg_pages_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_page_count(value);
  endtask

  // Mostly well-formed traffic on live allocations, with some noise mixed in.
  task automatic send_random_request();
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    int               lim;
    int               pages;
    int               first_page;
    int               run_pages;
    int               pick;
    bit               have_live;
    lim       = tracker.scan_limit();
    have_live = tracker.pick_live(first_page, run_pages);
    pick      = $urandom_range(0, 99);
    req       = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
    off       = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
    if (pick < 38) begin
      cmd = CMD_ALLOC;
      if ($urandom_range(0, 19) == 0) begin
        pages = $urandom_range(1, lim + 1);
      end else begin
        pages = $urandom_range(1, (lim < 8) ? ((lim < 1) ? 1 : lim) : 8);
      end
      if ($urandom_range(0, 19) != 0) begin
        req = REQ_W'((pages - 1) * PBYTES + $urandom_range(1, PBYTES));
      end
    end else if (pick < 68) begin
      cmd = CMD_FREE;
      if (have_live && $urandom_range(0, 9) < 7) begin
        off = OFF_W'(first_page * PBYTES + $urandom_range(0, PBYTES - 1));
      end else if (have_live && $urandom_range(0, 1) == 0) begin
        off = OFF_W'(first_page * PBYTES + $urandom_range(0, run_pages * PBYTES - 1));
      end
    end else if (pick < 90) begin
      cmd = CMD_FIND;
      if (have_live && $urandom_range(0, 9) < 6) begin
        off = OFF_W'(first_page * PBYTES + $urandom_range(0, run_pages * PBYTES - 1));
      end
    end else begin
      cmd = CMD_W'($urandom_range(0, 3));
    end
    send_request(cmd, req, off);
  endtask

  // Main sequence.
  initial begin
    int page_counts [12];
    page_counts = '{256, 16, 1, 511, 0, 64, 3, 256, 0, 300, 8, 128};
    page_counts[8] = $urandom_range(2, 255);
    tracker = new();

    // Reset is held, then released; the block then clears its map.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset page count.
    send_request(CMD_ALLOC, 21'd0, '0);
    send_request(CMD_ALLOC, 21'd1, '0);
    send_request(CMD_ALLOC, 21'd4096, '0);
    send_request(CMD_ALLOC, 21'd4097, '0);
    send_request(CMD_FIND, '0, 20'd12292);
    send_request(CMD_FIND, '0, 20'hFFFFF);
    send_request(CMD_FREE, '0, 20'd12288);
    send_request(CMD_FREE, '0, 20'hFFFFF);
    send_request(CMD_UNUSED, 21'h1FFFFF, 20'hFFFFF);
    send_request(CMD_FREE, '0, 20'd4103);
    send_request(CMD_ALLOC, 21'd1048576, '0);
    send_request(CMD_ALLOC, 21'h1FFFFF, '0);
    send_request(CMD_FREE, '0, 20'd0);
    send_request(CMD_FREE, '0, 20'd8192);
    send_request(CMD_ALLOC, 21'd1048576, '0);
    send_request(CMD_FIND, '0, 20'hFFFFF);
    send_request(CMD_FREE, '0, 20'd0);

    // A single managed page: frees past the end are rejected.
    write_page_count(9'd1);
    send_request(CMD_ALLOC, 21'd4096, '0);
    send_request(CMD_ALLOC, 21'd1, '0);
    send_request(CMD_FIND, '0, 20'd4095);
    send_request(CMD_FREE, '0, 20'd4096);
    send_request(CMD_FREE, '0, 20'd0);

    // No managed pages at all.
    write_page_count(9'd0);
    send_request(CMD_ALLOC, 21'd1, '0);
    send_request(CMD_FREE, '0, 20'd0);
    send_request(CMD_FIND, '0, 20'd0);

    // Random traffic, one phase per page count.
    foreach (page_counts[p]) begin
      write_page_count(CFG_W'(page_counts[p]));
      no_idle = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 5 && n == PHASE_ITEMS / 2) || $urandom_range(0, 149) == 0) begin
          wait_replies_done();
        end
        if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
        send_random_request();
      end
    end

    // Drain, then allow for a full scan before the verdict.
    wait_replies_done();
    repeat (2 * PAGES + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
